// ===== hw/rtl/eitp_pkg.sv =====
package eitp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_PIL     = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // Descriptor tags
  localparam logic [7:0] TAG_CONTENT = 8'h54;
  localparam logic [7:0] TAG_PDC     = 8'h69;

  // Parse position codes: header bytes, then the descriptor loop phases
  localparam logic [3:0] POS_EID_HI  = 4'd0;
  localparam logic [3:0] POS_EID_LO  = 4'd1;
  localparam logic [3:0] POS_MJD_HI  = 4'd2;
  localparam logic [3:0] POS_MJD_LO  = 4'd3;
  localparam logic [3:0] POS_START_H = 4'd4;
  localparam logic [3:0] POS_START_S = 4'd6;
  localparam logic [3:0] POS_DUR_H   = 4'd7;
  localparam logic [3:0] POS_DUR_S   = 4'd9;
  localparam logic [3:0] POS_LOOP_HI = 4'd10;
  localparam logic [3:0] POS_LOOP_LO = 4'd11;
  localparam logic [3:0] POS_TAG     = 4'd12;
  localparam logic [3:0] POS_LEN     = 4'd13;
  localparam logic [3:0] POS_BODY    = 4'd14;
  localparam logic [3:0] POS_DONE    = 4'd15;

  // Time unit selects for BCD fields
  localparam logic [1:0] UNIT_HOURS   = 2'd0;
  localparam logic [1:0] UNIT_MINUTES = 2'd1;

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] event_id;
    logic [15:0] mjd_date;
    logic [19:0] start_seconds;
    logic [19:0] duration_seconds;
    logic [2:0]  run_status;
    logic [15:0] content_code;
    logic [19:0] pil_value;
    logic        overrun_error;
    logic        last_result;
  } eitp_res_t;

  // Up to two results pushed per byte, r0 first
  typedef struct packed {
    logic [1:0] n;
    eitp_res_t  r0;
    eitp_res_t  r1;
  } eitp_push_t;

  function automatic logic [19:0] bcd_seconds(input logic [7:0] b, input logic [1:0] unit_sel);
    logic [7:0] v;
    v = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
    case (unit_sel)
      UNIT_HOURS:   return {12'd0, v} * 20'd3600;
      UNIT_MINUTES: return {12'd0, v} * 20'd60;
      default:      return {12'd0, v};
    endcase
  endfunction

endpackage

// ===== hw/rtl/eitp_chan_if.sv =====
interface eitp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface eitp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] event_id;
  logic [15:0] mjd_date;
  logic [19:0] start_seconds;
  logic [19:0] duration_seconds;
  logic [2:0]  run_status;
  logic [15:0] content_code;
  logic [19:0] pil_value;
  logic        overrun_error;
  logic        last_result;

  modport source (output valid, output kind, output event_id, output mjd_date,
                  output start_seconds, output duration_seconds, output run_status,
                  output content_code, output pil_value, output overrun_error,
                  output last_result, input ready);
  modport sink   (input valid, input kind, input event_id, input mjd_date,
                  input start_seconds, input duration_seconds, input run_status,
                  input content_code, input pil_value, input overrun_error,
                  input last_result, output ready);
endinterface

// ===== hw/rtl/eitp_parse.sv =====
module eitp_parse
  import eitp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  output eitp_push_t push
);

  logic [3:0]  pos_r, pos_nxt;
  logic [11:0] loop_r, loop_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [7:0]  dpos_r, dpos_nxt;
  logic [15:0] eid_r, eid_nxt;
  logic [15:0] mjd_r, mjd_nxt;
  logic [19:0] start_r, start_nxt;
  logic [19:0] dur_r, dur_nxt;
  logic [2:0]  run_r, run_nxt;
  logic [15:0] pil_sh_r, pil_sh_nxt;
  logic        pil_seen_r, pil_seen_nxt;
  logic [7:0]  code_hi_r, code_hi_nxt;

  eitp_res_t  prim, end_res;
  logic       prim_v, end_v, end_err, desc_done;
  logic [1:0] unit_sel;

  always_comb begin
    pos_nxt      = pos_r;
    loop_nxt     = loop_r;
    tag_nxt      = tag_r;
    dlen_nxt     = dlen_r;
    dpos_nxt     = dpos_r;
    eid_nxt      = eid_r;
    mjd_nxt      = mjd_r;
    start_nxt    = start_r;
    dur_nxt      = dur_r;
    run_nxt      = run_r;
    pil_sh_nxt   = pil_sh_r;
    pil_seen_nxt = pil_seen_r;
    code_hi_nxt  = code_hi_r;
    prim         = '0;
    prim_v       = 1'b0;
    end_v        = 1'b0;
    end_err      = 1'b0;
    desc_done    = 1'b0;
    unit_sel     = UNIT_HOURS;

    if (in_fire) begin
      // New entry: drop whatever is in progress
      if (in_first_byte) begin
        pos_nxt      = POS_EID_HI;
        loop_nxt     = '0;
        tag_nxt      = '0;
        dlen_nxt     = '0;
        dpos_nxt     = '0;
        eid_nxt      = '0;
        mjd_nxt      = '0;
        start_nxt    = '0;
        dur_nxt      = '0;
        run_nxt      = '0;
        pil_sh_nxt   = '0;
        pil_seen_nxt = 1'b0;
        code_hi_nxt  = '0;
      end

      if (pos_nxt < POS_TAG) begin
        if (pos_nxt == POS_EID_HI) begin
          eid_nxt = eid_nxt | {in_data_byte, 8'h00};
        end else if (pos_nxt == POS_EID_LO) begin
          eid_nxt = eid_nxt | {8'h00, in_data_byte};
        end else if (pos_nxt == POS_MJD_HI) begin
          mjd_nxt = mjd_nxt | {in_data_byte, 8'h00};
        end else if (pos_nxt == POS_MJD_LO) begin
          mjd_nxt = mjd_nxt | {8'h00, in_data_byte};
        end else if (pos_nxt <= POS_START_S) begin
          unit_sel  = pos_nxt[1:0] - POS_START_H[1:0];
          start_nxt = start_nxt + bcd_seconds(in_data_byte, unit_sel);
        end else if (pos_nxt <= POS_DUR_S) begin
          unit_sel = pos_nxt[1:0] - POS_DUR_H[1:0];
          dur_nxt  = dur_nxt + bcd_seconds(in_data_byte, unit_sel);
        end else if (pos_nxt == POS_LOOP_HI) begin
          run_nxt  = in_data_byte[7:5];
          loop_nxt = {in_data_byte[3:0], 8'h00};
        end else begin
          loop_nxt               = loop_nxt | {4'h0, in_data_byte};
          prim_v                 = 1'b1;
          prim.kind              = KIND_HEADER;
          prim.event_id          = eid_nxt;
          prim.mjd_date          = mjd_nxt;
          prim.start_seconds     = start_nxt;
          prim.duration_seconds  = dur_nxt;
          prim.run_status        = run_nxt;
        end
        if (pos_nxt == POS_LOOP_LO && loop_nxt == '0) begin
          end_v = 1'b1;
        end
        pos_nxt = pos_nxt + 4'd1;
      end else if (pos_nxt == POS_TAG) begin
        if (loop_nxt < 12'd2) begin
          end_v   = 1'b1;
          end_err = 1'b1;
        end else begin
          loop_nxt = loop_nxt - 12'd1;
          tag_nxt  = in_data_byte;
          pos_nxt  = POS_LEN;
        end
      end else if (pos_nxt == POS_LEN) begin
        loop_nxt = loop_nxt - 12'd1;
        dlen_nxt = in_data_byte;
        dpos_nxt = '0;
        if ({4'h0, in_data_byte} > loop_nxt) begin
          end_v   = 1'b1;
          end_err = 1'b1;
        end else if (in_data_byte == 8'd0) begin
          desc_done = 1'b1;
        end else begin
          pos_nxt = POS_BODY;
        end
      end else if (pos_nxt == POS_BODY) begin
        loop_nxt = loop_nxt - 12'd1;
        if (tag_nxt == TAG_CONTENT) begin
          if (!dpos_nxt[0]) begin
            code_hi_nxt = in_data_byte;
          end else begin
            prim_v            = 1'b1;
            prim.kind         = KIND_CONTENT;
            prim.content_code = {code_hi_nxt, in_data_byte};
          end
        end else if (tag_nxt == TAG_PDC && !pil_seen_nxt) begin
          if (dpos_nxt == 8'd0) begin
            pil_sh_nxt = {in_data_byte, 8'h00};
          end else if (dpos_nxt == 8'd1) begin
            pil_sh_nxt[7:0] = in_data_byte;
          end else if (dpos_nxt == 8'd2) begin
            prim_v         = 1'b1;
            prim.kind      = KIND_PIL;
            prim.pil_value = {pil_sh_nxt[11:0], in_data_byte};
          end
        end
        dpos_nxt = dpos_nxt + 8'd1;
        if (dpos_nxt >= dlen_nxt) begin
          desc_done = 1'b1;
        end
      end
      // done phase: ignore the byte

      if (desc_done) begin
        if (tag_nxt == TAG_PDC) begin
          pil_seen_nxt = 1'b1;
        end
        if (loop_nxt == '0) begin
          end_v = 1'b1;
        end else begin
          pos_nxt = POS_TAG;
        end
      end

      if (end_v) begin
        pos_nxt = POS_DONE;
      end
    end
  end

  always_comb begin
    end_res               = '0;
    end_res.kind          = KIND_END;
    end_res.overrun_error = end_err;
    end_res.last_result   = 1'b1;

    push = '0;
    if (prim_v) begin
      push.r0             = prim;
      push.r0.last_result = !end_v;
      push.r1             = end_res;
    end else begin
      push.r0 = end_res;
    end
    push.n = {1'b0, prim_v} + {1'b0, end_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_EID_HI;
      loop_r     <= '0;
      tag_r      <= '0;
      dlen_r     <= '0;
      dpos_r     <= '0;
      eid_r      <= '0;
      mjd_r      <= '0;
      start_r    <= '0;
      dur_r      <= '0;
      run_r      <= '0;
      pil_sh_r   <= '0;
      pil_seen_r <= 1'b0;
      code_hi_r  <= '0;
    end else begin
      pos_r      <= pos_nxt;
      loop_r     <= loop_nxt;
      tag_r      <= tag_nxt;
      dlen_r     <= dlen_nxt;
      dpos_r     <= dpos_nxt;
      eid_r      <= eid_nxt;
      mjd_r      <= mjd_nxt;
      start_r    <= start_nxt;
      dur_r      <= dur_nxt;
      run_r      <= run_nxt;
      pil_sh_r   <= pil_sh_nxt;
      pil_seen_r <= pil_seen_nxt;
      code_hi_r  <= code_hi_nxt;
    end
  end

  a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.r1.kind == KIND_END && push.r0.kind != KIND_END)
    else $error("two results without a closing end result");

  a_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    end_v |=> pos_r == POS_DONE)
    else $error("end result did not close the entry");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_first_byte && pos_r == POS_DONE |-> push.n == 2'd0)
    else $error("result from a finished entry");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |-> push.n == 2'd0)
    else $error("result without an accepted item");

endmodule

// ===== hw/rtl/eitp_res_fifo.sv =====
module eitp_res_fifo
  import eitp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  eitp_push_t push,
  output logic       room,
  eitp_out_if.source out_chan
);

  eitp_res_t              mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_r, wr_nxt;
  logic [RES_PTR_W-1:0]   rd_r, rd_nxt;
  logic [RES_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   pop;
  eitp_res_t              head;

  // Keep room for two results from one item
  assign room = cnt_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign pop  = out_chan.valid && out_chan.ready;
  assign head = mem_r[rd_r];

  assign out_chan.valid            = cnt_r != '0;
  assign out_chan.kind             = head.kind;
  assign out_chan.event_id         = head.event_id;
  assign out_chan.mjd_date         = head.mjd_date;
  assign out_chan.start_seconds    = head.start_seconds;
  assign out_chan.duration_seconds = head.duration_seconds;
  assign out_chan.run_status       = head.run_status;
  assign out_chan.content_code     = head.content_code;
  assign out_chan.pil_value        = head.pil_value;
  assign out_chan.overrun_error    = head.overrun_error;
  assign out_chan.last_result      = head.last_result;

  always_comb begin
    wr_nxt  = wr_r + RES_PTR_W'(push.n);
    rd_nxt  = rd_r + RES_PTR_W'(pop);
    cnt_nxt = cnt_r + RES_CNT_W'(push.n) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_r + RES_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> cnt_r <= RES_CNT_W'(RES_DEPTH - 2))
    else $error("push into a queue without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    RES_PTR_W'(wr_r - rd_r) == RES_PTR_W'(cnt_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/eit_event_header_descriptor_parser_core.sv =====
// Latency: results are registered in the result queue; a result is offered on out_chan
// the cycle after its byte is accepted if no older result is waiting. Throughput: one
// byte per cycle; the four-entry queue drops in_chan.ready when it holds over two
// results, which keeps room for bytes with two (header, code or pil with end).
// Reset (rst_n low, synchronous): parse state cleared, queue emptied.
module eit_event_header_descriptor_parser_core
  import eitp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  eitp_in_if.sink    in_chan,
  eitp_out_if.source out_chan
);

  eitp_push_t push;
  logic       room;
  logic       fire;

  assign in_chan.ready = room;
  assign fire          = in_chan.valid && room;

  eitp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (fire),
    .in_data_byte  (in_chan.data_byte),
    .in_first_byte (in_chan.first_byte),
    .push          (push)
  );

  eitp_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule
